// ===== sv/sra_pkg.sv =====
// Package for the sparse row accumulator: widths, payload structs, command
// and status structs, and the saturating accumulate function.
// Depends on nothing; every other file but sra_ram imports it.
`timescale 1ns / 1ps

package sra_pkg;

  // Sizing of the row store and column map.
  localparam int NUM_COLUMNS = 1024;
  localparam int ROW_CAP     = 64;

  // Fixed field widths.
  localparam int COL_W  = 10;
  localparam int FAC_W  = 16;
  localparam int PROD_W = 2 * FAC_W;
  localparam int SUM_W  = 40;
  localparam int CNT_W  = 7;

  // Derived sizes of the stores.
  localparam int SLOT_W    = (ROW_CAP > 1) ? $clog2(ROW_CAP) : 1;
  localparam int MAP_DEPTH = (NUM_COLUMNS < (1 << COL_W)) ? NUM_COLUMNS : (1 << COL_W);
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // Function codes of an input item.
  localparam logic FUNC_TERM  = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  // Saturation limits of a sum.
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic                    func;
    logic [COL_W-1:0]        out_column;
    logic signed [FAC_W-1:0] left_factor;
    logic signed [FAC_W-1:0] right_factor;
  } term_t;

  typedef struct packed {
    logic [COL_W-1:0]        result_column;
    logic signed [SUM_W-1:0] result_value;
    logic                    last_of_row;
    logic                    empty_row;
    logic                    row_overflow;
    logic [CNT_W-1:0]        row_nonzeros;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic lookup;
    logic update;
    logic close_rd;
    logic emit;
    logic emit_empty;
    logic clear_row;
  } sra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic used_zero;
    logic out_free;
    logic last_slot;
  } sra_status_t;

  // Adds a product to a sum and clamps to the signed sum range.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  sum,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [SUM_W:0] total;
    total = {sum[SUM_W-1], sum} + {{(SUM_W+1-PROD_W){prod[PROD_W-1]}}, prod};
    if (total[SUM_W] != total[SUM_W-1]) begin
      return total[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return total[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/sra_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sra_ctrl.sv =====
// Controller state machine of the sparse row accumulator: sequences term
// lookups and updates, and the walk over the row store at a close.
// Depends on sra_pkg.
`timescale 1ns / 1ps

module sra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                term_valid,
  input  logic                term_func,
  output logic                term_stall,
  input  sra_pkg::sra_status_t status,
  output sra_pkg::sra_cmd_t   cmd
);

  import sra_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_UPD   = 6'b000100,
    S_CRD   = 6'b001000,
    S_CLD   = 6'b010000,
    S_EMPTY = 6'b100000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An item is taken only when no earlier item is at work.
  assign term_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (term_valid) begin
          cmd.take = 1'b1;
          if (term_func == FUNC_CLOSE) begin
            state_next = status.used_zero ? S_EMPTY : S_CRD;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      S_CRD: begin
        cmd.close_rd = 1'b1;
        state_next   = S_CLD;
      end
      S_CLD: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_slot) begin
            cmd.clear_row = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_CRD;
          end
        end
      end
      S_EMPTY: begin
        if (status.out_free) begin
          cmd.emit_empty = 1'b1;
          cmd.clear_row  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/sra_dp.sv =====
// Datapath of the sparse row accumulator: multiplier, column map, slot
// stores, saturating accumulate and the output register.
// Depends on sra_pkg and sra_ram.
`timescale 1ns / 1ps

module sra_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sra_pkg::term_t       term,
  input  sra_pkg::sra_cmd_t    cmd,
  output sra_pkg::sra_status_t status,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sra_pkg::result_t     result
);

  import sra_pkg::*;

  logic [COL_W-1:0]         col_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]         used_slots;
  logic                     overflow_seen;
  logic [SLOT_W-1:0]        idx;

  logic [SLOT_W-1:0]        map_rdata;
  logic [COL_W-1:0]         cols_rdata;
  logic [SUM_W-1:0]         sums_rdata;

  logic                     in_range;
  logic                     hit;
  logic                     full;
  logic                     new_slot;
  logic                     map_we;
  logic                     sums_we;
  logic [SLOT_W-1:0]        sums_waddr;
  logic signed [SUM_W-1:0]  sums_wdata;
  logic                     slot_re;
  logic [SLOT_W-1:0]        slot_raddr;

  // Registered term fields and product; both factors are sign-extended first.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      col_q  <= term.out_column;
      prod_q <= PROD_W'(term.left_factor) * PROD_W'(term.right_factor);
    end
  end

  // A map entry counts only if its slot is in use and points back at the column.
  always_comb begin
    hit = 1'b0;
    if ({{(CNT_W-SLOT_W){1'b0}}, map_rdata} < used_slots) begin
      if (cols_rdata == col_q) begin
        hit = 1'b1;
      end
    end
  end

  assign in_range = (int'(col_q) < NUM_COLUMNS);
  assign full     = (used_slots == CNT_W'(ROW_CAP));
  assign new_slot = cmd.update && in_range && !hit && !full;
  assign map_we   = new_slot;
  assign sums_we  = new_slot || (cmd.update && in_range && hit);

  // Accumulate into the held slot, or start a fresh one.
  always_comb begin
    if (hit) begin
      sums_waddr = map_rdata;
      sums_wdata = sat_add(sums_rdata, prod_q);
    end else begin
      sums_waddr = used_slots[SLOT_W-1:0];
      sums_wdata = sat_add('0, prod_q);
    end
  end

  // Slot stores are read at the mapped slot on lookup and at idx on close.
  assign slot_re    = cmd.lookup || cmd.close_rd;
  assign slot_raddr = cmd.lookup ? map_rdata : idx;

  sra_ram #(.WIDTH(SLOT_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (col_q[MAP_AW-1:0]),
    .wdata (used_slots[SLOT_W-1:0]),
    .re    (cmd.take),
    .raddr (term.out_column[MAP_AW-1:0]),
    .rdata (map_rdata)
  );

  sra_ram #(.WIDTH(COL_W), .DEPTH(ROW_CAP)) u_cols (
    .clk   (clk),
    .we    (new_slot),
    .waddr (used_slots[SLOT_W-1:0]),
    .wdata (col_q),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (cols_rdata)
  );

  sra_ram #(.WIDTH(SUM_W), .DEPTH(ROW_CAP)) u_sums (
    .clk   (clk),
    .we    (sums_we),
    .waddr (sums_waddr),
    .wdata (sums_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (sums_rdata)
  );

  // Row bookkeeping: slot count and overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.clear_row) begin
      used_slots    <= '0;
      overflow_seen <= 1'b0;
    end else if (new_slot) begin
      used_slots <= used_slots + CNT_W'(1);
    end else if (cmd.update && in_range && !hit && full) begin
      overflow_seen <= 1'b1;
    end
  end

  // Walk index over the slots at a close.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx <= '0;
    end else if (cmd.emit) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.result_column <= cols_rdata;
      result.result_value  <= sums_rdata;
      result.last_of_row   <= status.last_slot;
      result.empty_row     <= 1'b0;
      result.row_overflow  <= overflow_seen;
      result.row_nonzeros  <= used_slots;
    end else if (cmd.emit_empty) begin
      result.result_column <= '0;
      result.result_value  <= '0;
      result.last_of_row   <= 1'b1;
      result.empty_row     <= 1'b1;
      result.row_overflow  <= overflow_seen;
      result.row_nonzeros  <= used_slots;
    end
  end

  // Status to the controller.
  assign status.used_zero = (used_slots == '0);
  assign status.out_free  = !result_valid || !result_stall;
  assign status.last_slot = ({{(CNT_W-SLOT_W){1'b0}}, idx} + CNT_W'(1) == used_slots);

endmodule

// ===== sv/sparse_row_accumulator_top.sv =====
// Top level of the sparse row accumulator: controller and datapath.
// Depends on sra_pkg, sra_ctrl, sra_dp.
//
//   Channel  Direction  Handshake                  Payload
//   term     in         term_valid / term_stall    sra_pkg::term_t
//   result   out        result_valid / result_stall sra_pkg::result_t
//
// A term item goes through a column map read, a slot store read, then the
// saturating update written back to the slot stores.
// A close item walks the row one column at a time (slot store read, then
// output register load), or loads a single empty-row marker for an empty
// row; the walk waits while the result side stalls.
// Reset is synchronous; the column map needs no clearing pass, since a map
// entry is trusted only when its slot is in use and holds the same column.
// A finished item sits in the output register while the next term is taken.
`timescale 1ns / 1ps

module sparse_row_accumulator_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             term_valid,
  output logic             term_stall,
  input  sra_pkg::term_t   term,
  output logic             result_valid,
  input  logic             result_stall,
  output sra_pkg::result_t result
);

  import sra_pkg::*;

  sra_cmd_t    cmd;
  sra_status_t status;

  sra_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .term_valid (term_valid),
    .term_func  (term.func),
    .term_stall (term_stall),
    .status     (status),
    .cmd        (cmd)
  );

  sra_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .term         (term),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== sv/sra_checker.sv =====
// Port-level checker of the sparse row accumulator, bound to the top level.
// Depends on sra_pkg and sparse_row_accumulator_top.
`timescale 1ns / 1ps

module sra_checker (
  input logic             clk,
  input logic             rst,
  input logic             term_valid,
  input logic             term_stall,
  input sra_pkg::term_t   term,
  input logic             result_valid,
  input logic             result_stall,
  input sra_pkg::result_t result
);

  import sra_pkg::*;

  // A stalled result item holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result item changed while stalled");

  // Every taken item keeps the block busy, so two items are never taken back to back.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    term_valid && !term_stall |=> term_stall)
    else $error("term taken on two consecutive cycles");

  // The empty marker is a lone, zero item.
  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.empty_row |->
      result.last_of_row && result.result_column == '0 &&
      result.result_value == '0 && result.row_nonzeros == '0)
    else $error("malformed empty row marker");

  // A real nonzero comes from a row holding between one and ROW_CAP columns.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.empty_row |->
      result.row_nonzeros != '0 && result.row_nonzeros <= CNT_W'(ROW_CAP))
    else $error("row nonzero count out of range");

endmodule

bind sparse_row_accumulator_top sra_checker u_sra_checker (.*);

// ===== bench/tb.sv =====
// Testbench for sparse_row_accumulator_top: streams term and close items, predicts
// every emitted row entry in a scoreboard class and checks results in order.
// Depends on sra_pkg and the RTL of sparse_row_accumulator_top.
`timescale 1ns / 1ps

module tb;
  import sra_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 40;
  localparam int IDLE_PCT     = 19;
  localparam int DRAIN_CYCLES = 20;

  // Tracks the row being accumulated and the row entries still owed by the block.
  class row_sum_scoreboard;
    bit                      col_held [NUM_COLUMNS];
    bit [CNT_W-1:0]          col_slot [NUM_COLUMNS];
    bit [COL_W-1:0]          slot_col [ROW_CAP];
    bit signed [SUM_W-1:0]   slot_sum [ROW_CAP];
    int unsigned             used;
    bit                      overflowed;
    result_t                 owed_entries[$];
    int                      failures;

    function bit signed [SUM_W-1:0] clamp_sum(longint v);
      if (v > longint'(SUM_MAX)) begin
        return SUM_MAX;
      end
      if (v < longint'(SUM_MIN)) begin
        return SUM_MIN;
      end
      return v[SUM_W-1:0];
    endfunction

    // Applies one accepted item to the row state; a close queues its row entries.
    function void take_term(term_t t);
      longint      prod;
      int unsigned idx;
      result_t     r;
      if (t.func == FUNC_TERM) begin
        prod = longint'($signed(t.left_factor)) * longint'($signed(t.right_factor));
        if (col_held[t.out_column]) begin
          idx = col_slot[t.out_column];
          slot_sum[idx] = clamp_sum(longint'(slot_sum[idx]) + prod);
        end else if (used >= ROW_CAP) begin
          overflowed = 1'b1;
        end else begin
          col_held[t.out_column] = 1'b1;
          col_slot[t.out_column] = CNT_W'(used);
          slot_col[used] = t.out_column;
          slot_sum[used] = clamp_sum(prod);
          used++;
        end
      end else begin
        if (used == 0) begin
          r = '0;
          r.last_of_row  = 1'b1;
          r.empty_row    = 1'b1;
          r.row_overflow = overflowed;
          owed_entries.insert(owed_entries.size(), r);
        end
        for (int s = 0; s < used; s++) begin
          r.result_column = slot_col[s];
          r.result_value  = slot_sum[s];
          r.last_of_row   = (s == used - 1);
          r.empty_row     = 1'b0;
          r.row_overflow  = overflowed;
          r.row_nonzeros  = CNT_W'(used);
          owed_entries.insert(owed_entries.size(), r);
          col_held[slot_col[s]] = 1'b0;
        end
        used = 0;
        overflowed = 1'b0;
      end
    endfunction

    // Compares one accepted result with the oldest owed row entry.
    function void check_result(result_t got);
      result_t want;
      if (owed_entries.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: col %0d value %0d last %0b empty %0b",
                   got.result_column, got.result_value, got.last_of_row, got.empty_row);
        end
        return;
      end
      want = owed_entries.pop_front();
      if (got.result_column !== want.result_column || got.result_value !== want.result_value ||
          got.last_of_row !== want.last_of_row || got.empty_row !== want.empty_row ||
          got.row_overflow !== want.row_overflow ||
          got.row_nonzeros !== want.row_nonzeros) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected col %0d value %0d last %0b empty %0b ovf %0b nz %0d",
                   want.result_column, want.result_value, want.last_of_row,
                   want.empty_row, want.row_overflow, want.row_nonzeros);
          $display("          actual   col %0d value %0d last %0b empty %0b ovf %0b nz %0d",
                   got.result_column, got.result_value, got.last_of_row,
                   got.empty_row, got.row_overflow, got.row_nonzeros);
        end
      end
    endfunction

    function int outstanding();
      return owed_entries.size();
    endfunction

    function int failure_count();
      return failures + owed_entries.size();
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    term_valid;
  logic    term_stall;
  term_t   term;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  logic    term_fire;
  logic    result_fire;

  bit                idle_on;
  bit                hold_req;
  int                items_sent;
  row_sum_scoreboard sb;

  sparse_row_accumulator_top dut (
    .clk          (clk),
    .rst          (rst),
    .term_valid   (term_valid),
    .term_stall   (term_stall),
    .term         (term),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign term_fire   = term_valid && !term_stall;
  assign result_fire = result_valid && !result_stall;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Factors lean toward the extremes, zero and small values.
  function automatic logic signed [FAC_W-1:0] rand_factor();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return FAC_W'(int'($urandom_range(200)) - 100);
      default: return FAC_W'($urandom);
    endcase
  endfunction

  // Offers one item at a falling edge and returns at the falling edge after it is taken.
  task automatic offer(input term_t t);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      term_valid <= 1'b0;
      @(negedge clk);
    end
    term_valid <= 1'b1;
    term <= t;
    do @(posedge clk); while (term_stall);
    sb.take_term(t);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_term(input logic [COL_W-1:0] col, input logic signed [FAC_W-1:0] a,
                           input logic signed [FAC_W-1:0] b);
    term_t t;
    t.func         = FUNC_TERM;
    t.out_column   = col;
    t.left_factor  = a;
    t.right_factor = b;
    offer(t);
  endtask

  // The other fields of a close item carry noise; the block ignores them.
  task automatic send_close();
    term_t t;
    t.func         = FUNC_CLOSE;
    t.out_column   = COL_W'($urandom);
    t.left_factor  = FAC_W'($urandom);
    t.right_factor = FAC_W'($urandom);
    offer(t);
  endtask

  // A row draws mostly from a small column pool so that columns repeat.
  task automatic random_row(input int n_terms);
    logic [COL_W-1:0] pool [6];
    logic [COL_W-1:0] col;
    foreach (pool[k]) pool[k] = COL_W'($urandom);
    for (int i = 0; i < n_terms; i++) begin
      col = ($urandom_range(99) < 15) ? COL_W'($urandom) : pool[$urandom_range(5)];
      send_term(col, rand_factor(), rand_factor());
    end
    send_close();
  endtask

  // Holds the term side idle until every owed row entry has come out.
  task automatic pause_until_drained();
    term_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  // Result side: random stalls, or one long hold when asked.
  initial begin : result_side
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        result_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_fire) begin
      sb.check_result(result);
    end
  end

  // Ends the run when neither channel moves an item for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || term_fire || result_fire) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int first_random;
    int stride;
    int base;
    sb = new;
    idle_on = 1'b1;
    rst = 1'b1;
    term_valid = 1'b0;
    term = '0;
    items_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty rows, extreme factors, repeated columns, zero products.
    send_close();
    send_term(10'd0, 16'sh8000, 16'sh8000);
    send_term(10'd1023, 16'sh8000, 16'sh7FFF);
    send_term(10'd0, 16'sh7FFF, 16'sh7FFF);
    send_term(10'd512, 16'sh0000, 16'sh3039);
    send_term(10'd1023, 16'sh0001, 16'shFFFF);
    send_close();
    send_close();
    send_term(10'h155, 16'sh5555, 16'shAAAA);
    send_term(10'h2AA, 16'shAAAA, 16'sh5555);
    send_term(10'h155, 16'sh7FFF, 16'sh8000);
    send_term(10'h2AA, 16'shFFFF, 16'shFFFF);
    send_close();
    send_term(10'd7, 16'sh0064, 16'sh0064);
    send_term(10'd7, 16'shFF9C, 16'sh0064);
    send_close();

    // The result side holds off while rows keep coming, so the input backs up.
    hold_req = 1'b1;
    repeat (4) random_row(5);
    pause_until_drained();

    // No idling here: a row that fills the store and then overflows it while
    // held columns keep accumulating.
    idle_on = 1'b0;
    stride = 2 * $urandom_range(511) + 1;
    base   = $urandom_range(1023);
    for (int i = 0; i < ROW_CAP + 6; i++) begin
      send_term(COL_W'(base + i * stride), rand_factor(), rand_factor());
      if (i >= ROW_CAP) begin
        send_term(COL_W'(base + (i - 60) * stride), rand_factor(), rand_factor());
      end
    end
    send_close();
    idle_on = 1'b1;

    // Random rows, mostly short, with an occasional longer or empty one.
    first_random = items_sent;
    while (items_sent - first_random < RANDOM_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        random_row($urandom_range(8, 16));
      end else begin
        random_row($urandom_range(0, 6));
      end
    end

    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failure_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sra_pkg.sv
sv/sra_ram.sv
sv/sra_ctrl.sv
sv/sra_dp.sv
sv/sparse_row_accumulator_top.sv
sv/sra_checker.sv
bench/tb.sv
